// ----- rtl/core/tet_element_stiffness_assert.svh -----
// Assertion shorthands for the element stiffness block
`ifndef TET_ELEMENT_STIFFNESS_ASSERT_SVH
`define TET_ELEMENT_STIFFNESS_ASSERT_SVH

// same-cycle implication
`define TES_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TES_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tes_pkg.sv -----
`timescale 1ns / 1ps
package tes_pkg;
   localparam int COORD_BITS = 32;
   localparam int OUT_BITS   = 48;
   localparam int SIXTH_DIV  = 6;

   localparam int EW    = COORD_BITS + 1;
   localparam int AW    = 2 * EW + 1;
   localparam int DW    = EW + AW + 2;
   localparam int GW    = AW + 2;
   localparam int PW    = 2 * GW + 2;
   localparam int HW    = DW + 3;
   localparam int NW    = PW + 2;
   localparam int QB    = OUT_BITS + 1;
   localparam int RW    = ((NW > HW + 1 + QB) ? NW : HW + 1 + QB) + 1;
   localparam int NPAIR = 10;

   // wide products are built from signed chunk products
   localparam int NCH = 3;
   localparam int CH  = (GW + NCH - 1) / NCH;
   localparam int XW  = NCH * CH;
   localparam int PPW = 2 * CH + 2;
   localparam int TW  = EW + AW;
   localparam int MW  = 2 * GW;

   // adjugate entry r*3+c = J[p]*J[q] - J[s]*J[t], J flattened as k*3+a
   localparam logic [3:0] MSEL [9][4] = '{
      '{4'd8, 4'd4, 4'd7, 4'd5},
      '{4'd7, 4'd2, 4'd8, 4'd1},
      '{4'd5, 4'd1, 4'd4, 4'd2},
      '{4'd6, 4'd5, 4'd8, 4'd3},
      '{4'd8, 4'd0, 4'd6, 4'd2},
      '{4'd3, 4'd2, 4'd5, 4'd0},
      '{4'd7, 4'd3, 4'd6, 4'd4},
      '{4'd6, 4'd1, 4'd7, 4'd0},
      '{4'd4, 4'd0, 4'd3, 4'd1}
   };

   // K is symmetric: ten distinct entries
   localparam logic [1:0] PAIR_A [NPAIR] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1,
                                              2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
   localparam logic [1:0] PAIR_B [NPAIR] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                              2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
   localparam logic [3:0] PAIR_OF [4][4] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3},
      '{4'd1, 4'd4, 4'd5, 4'd6},
      '{4'd2, 4'd5, 4'd7, 4'd8},
      '{4'd3, 4'd6, 4'd8, 4'd9}
   };

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x0;
      logic signed [COORD_BITS-1:0] y0;
      logic signed [COORD_BITS-1:0] z0;
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic signed [COORD_BITS-1:0] z1;
      logic signed [COORD_BITS-1:0] x2;
      logic signed [COORD_BITS-1:0] y2;
      logic signed [COORD_BITS-1:0] z2;
      logic signed [COORD_BITS-1:0] x3;
      logic signed [COORD_BITS-1:0] y3;
      logic signed [COORD_BITS-1:0] z3;
   } tes_req_type;

   typedef struct packed {
      logic [1:0]                 row_index;
      logic signed [OUT_BITS-1:0] entry0;
      logic signed [OUT_BITS-1:0] entry1;
      logic signed [OUT_BITS-1:0] entry2;
      logic signed [OUT_BITS-1:0] entry3;
      logic                       last_row;
      logic                       degenerate;
   } tes_rsp_type;
endpackage

// ----- rtl/core/tet_element_stiffness.sv -----
// channel   ports                        transfer when
// request   start, busy, req_data         start high, busy low
// response  rsp_valid, rsp_data           rsp_valid high (once per row)
//
// The four row transfers share one response port; a new request can be accepted
// while earlier elements are still in flight. The restoring divider takes one
// quotient bit per stage for ten distinct entries in parallel.
// busy is high after each request transfer while the spacing counter counts down.
// Synchronous reset clears valid bits, the spacing counter and the row sequencer.
// The receiver cannot stall; nothing in the pipeline waits.
`timescale 1ns / 1ps
`include "tet_element_stiffness_assert.svh"
module tet_element_stiffness (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tes_pkg::tes_req_type req_data,
   output logic                 rsp_valid,
   output tes_pkg::tes_rsp_type rsp_data
);
   import tes_pkg::*;

   localparam logic [QB-1:0] MAXPOS = {2'b00, {(OUT_BITS-1){1'b1}}};
   localparam logic [QB-1:0] MAXNEG = {2'b01, {(OUT_BITS-1){1'b0}}};

   logic signed [COORD_BITS-1:0] vtx [4][3];
   logic                         accept;
   logic [1:0]                   gap_ff, gap_in;

   logic                        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic signed [EW-1:0]        j1_ff  [9];
   logic signed [2*EW-1:0]      pm2_ff [9][2];
   logic signed [EW-1:0]        j2_ff  [3];
   logic signed [AW-1:0]        a3_ff  [9];
   logic signed [EW-1:0]        j3_ff  [3];
   logic signed [PPW-1:0]       dq4_ff [3][NCH][NCH];
   logic signed [GW-1:0]        g4_ff  [4][3];
   logic signed [TW-1:0]        dp5_ff [3];
   logic signed [PPW-1:0]       gq5_ff [NPAIR][3][NCH][NCH];
   logic signed [DW-1:0]        det6_ff;
   logic signed [MW-1:0]        pp6_ff [NPAIR][3];
   logic [HW-1:0]               half7_ff;
   logic                        dg7_ff;
   logic signed [PW-1:0]        dot7_ff [NPAIR];
   logic [NW-1:0]               n8_ff  [NPAIR];
   logic                        neg8_ff [NPAIR];
   logic [HW-1:0]               half8_ff;
   logic                        dg8_ff;

   logic signed [TW-1:0]        dps4 [3];
   logic signed [MW-1:0]        pps5 [NPAIR][3];
   logic [DW-1:0]               adet6;
   logic [PW-1:0]               mag7 [NPAIR];

   logic                        dv_ff  [QB+1];
   logic [RW-1:0]               rem_ff [QB][NPAIR];
   logic [QB-1:0]               q_ff   [QB+1][NPAIR];
   logic                        ng_ff  [QB+1][NPAIR];
   logic                        ov_ff  [QB+1][NPAIR];
   logic [HW:0]                 den_ff [QB];
   logic                        dgd_ff [QB+1];
   logic [RW-1:0]               rem_in [QB][NPAIR];
   logic                        ge     [QB][NPAIR];

   logic signed [OUT_BITS-1:0]  ent_in [NPAIR];
   logic signed [OUT_BITS-1:0]  ent_ff [NPAIR];
   logic                        odg_ff;
   logic                        act_ff, act_in;
   logic [1:0]                  row_ff, row_in;

   // chunk i of a sign-extended operand; only the top chunk carries the sign
   function automatic logic signed [CH:0] chunk_of(logic signed [XW-1:0] v, int i);
      logic top;
      top = (i == NCH - 1) ? v[XW-1] : 1'b0;
      return {top, v[i*CH +: CH]};
   endfunction

   always_comb begin
      vtx[0][0] = req_data.x0; vtx[0][1] = req_data.y0; vtx[0][2] = req_data.z0;
      vtx[1][0] = req_data.x1; vtx[1][1] = req_data.y1; vtx[1][2] = req_data.z1;
      vtx[2][0] = req_data.x2; vtx[2][1] = req_data.y2; vtx[2][2] = req_data.z2;
      vtx[3][0] = req_data.x3; vtx[3][1] = req_data.y3; vtx[3][2] = req_data.z3;
   end

   assign accept = start && !busy;
   assign busy   = (gap_ff != 2'd0);

   always_comb begin
      if (accept) begin
         gap_in = 2'd3;
      end else if (gap_ff != 2'd0) begin
         gap_in = gap_ff - 2'd1;
      end else begin
         gap_in = 2'd0;
      end
   end

   // chunk products summed back to full width
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dps4[c] = '0;
         for (int i = 0; i < NCH; i++) begin
            for (int k = 0; k < NCH; k++) begin
               dps4[c] = dps4[c] + (TW'(dq4_ff[c][i][k]) <<< ((i + k) * CH));
            end
         end
      end
      for (int p = 0; p < NPAIR; p++) begin
         for (int m = 0; m < 3; m++) begin
            pps5[p][m] = '0;
            for (int i = 0; i < NCH; i++) begin
               for (int k = 0; k < NCH; k++) begin
                  pps5[p][m] = pps5[p][m] + (MW'(gq5_ff[p][m][i][k]) <<< ((i + k) * CH));
               end
            end
         end
      end
   end

   // |det|, later scaled by 6 in the front end
   assign adet6 = det6_ff[DW-1] ? DW'(-det6_ff) : DW'(det6_ff);

   always_comb begin
      for (int p = 0; p < NPAIR; p++) begin
         mag7[p] = dot7_ff[p][PW-1] ? PW'(-dot7_ff[p]) : PW'(dot7_ff[p]);
      end
   end

   // front end: edges, minors, adjugate, det and dot products
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         for (int a = 0; a < 3; a++) begin
            j1_ff[k*3+a] <= EW'(vtx[a+1][k]) - EW'(vtx[0][k]);
         end
      end
      for (int i = 0; i < 9; i++) begin
         pm2_ff[i][0] <= j1_ff[MSEL[i][0]] * j1_ff[MSEL[i][1]];
         pm2_ff[i][1] <= j1_ff[MSEL[i][2]] * j1_ff[MSEL[i][3]];
      end
      for (int c = 0; c < 3; c++) begin
         j2_ff[c] <= j1_ff[c];
      end
      for (int i = 0; i < 9; i++) begin
         a3_ff[i] <= AW'(pm2_ff[i][0]) - AW'(pm2_ff[i][1]);
      end
      j3_ff <= j2_ff;
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < NCH; i++) begin
            for (int k = 0; k < NCH; k++) begin
               dq4_ff[c][i][k] <= chunk_of(XW'(j3_ff[c]), i) * chunk_of(XW'(a3_ff[c*3]), k);
            end
         end
         g4_ff[0][c] <= -(GW'(a3_ff[c]) + GW'(a3_ff[3+c]) + GW'(a3_ff[6+c]));
         for (int a = 0; a < 3; a++) begin
            g4_ff[a+1][c] <= GW'(a3_ff[a*3+c]);
         end
      end
      dp5_ff <= dps4;
      for (int p = 0; p < NPAIR; p++) begin
         for (int m = 0; m < 3; m++) begin
            for (int i = 0; i < NCH; i++) begin
               for (int k = 0; k < NCH; k++) begin
                  gq5_ff[p][m][i][k] <= chunk_of(XW'(g4_ff[PAIR_A[p]][m]), i)
                                      * chunk_of(XW'(g4_ff[PAIR_B[p]][m]), k);
               end
            end
         end
      end
      det6_ff  <= DW'(dp5_ff[0]) + DW'(dp5_ff[1]) + DW'(dp5_ff[2]);
      pp6_ff   <= pps5;
      half7_ff <= (HW'(adet6) << 2) + (HW'(adet6) << 1);
      dg7_ff   <= (det6_ff == '0);
      for (int p = 0; p < NPAIR; p++) begin
         dot7_ff[p] <= PW'(pp6_ff[p][0]) + PW'(pp6_ff[p][1]) + PW'(pp6_ff[p][2]);
      end
      // numerator 2|dot| + half
      for (int p = 0; p < NPAIR; p++) begin
         n8_ff[p]   <= (NW'(mag7[p]) << 1) + NW'(half7_ff);
         neg8_ff[p] <= dot7_ff[p][PW-1];
      end
      half8_ff <= half7_ff;
      dg8_ff   <= dg7_ff;
   end

   // restoring divider, one quotient bit per stage
   always_comb begin
      for (int d = 0; d < QB; d++) begin
         for (int p = 0; p < NPAIR; p++) begin
            ge[d][p]     = rem_ff[d][p] >= (RW'(den_ff[d]) << (QB - 1 - d));
            rem_in[d][p] = ge[d][p] ? rem_ff[d][p] - (RW'(den_ff[d]) << (QB - 1 - d))
                                    : rem_ff[d][p];
         end
      end
   end

   always_ff @(posedge clock) begin
      den_ff[0] <= {half8_ff, 1'b0};
      dgd_ff[0] <= dg8_ff;
      for (int p = 0; p < NPAIR; p++) begin
         rem_ff[0][p] <= RW'(n8_ff[p]);
         q_ff[0][p]   <= '0;
         ng_ff[0][p]  <= neg8_ff[p];
         ov_ff[0][p]  <= RW'(n8_ff[p]) >= (RW'({half8_ff, 1'b0}) << QB);
      end
      for (int d = 0; d < QB; d++) begin
         if (d + 1 < QB) begin
            den_ff[d+1] <= den_ff[d];
         end
         dgd_ff[d+1] <= dgd_ff[d];
         for (int p = 0; p < NPAIR; p++) begin
            if (d + 1 < QB) begin
               rem_ff[d+1][p] <= rem_in[d][p];
            end
            q_ff[d+1][p]  <= {q_ff[d][p][QB-2:0], ge[d][p]};
            ng_ff[d+1][p] <= ng_ff[d][p];
            ov_ff[d+1][p] <= ov_ff[d][p];
         end
      end
   end

   // rounding is folded into the numerator; saturate and sign here, zero when degenerate
   always_comb begin
      for (int p = 0; p < NPAIR; p++) begin
         if (dgd_ff[QB]) begin
            ent_in[p] = '0;
         end else if (!ng_ff[QB][p]) begin
            ent_in[p] = (ov_ff[QB][p] || q_ff[QB][p] > MAXPOS) ? OUT_BITS'(MAXPOS)
                                                               : OUT_BITS'(q_ff[QB][p]);
         end else begin
            ent_in[p] = (ov_ff[QB][p] || q_ff[QB][p] > MAXNEG) ? -OUT_BITS'(MAXNEG)
                                                               : -OUT_BITS'(q_ff[QB][p]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ff[QB]) begin
         ent_ff <= ent_in;
         odg_ff <= dgd_ff[QB];
      end
   end

   always_comb begin
      act_in = act_ff;
      row_in = row_ff;
      if (dv_ff[QB]) begin
         act_in = 1'b1;
         row_in = 2'd0;
      end else if (act_ff) begin
         row_in = row_ff + 2'd1;
         if (row_ff == 2'd3) begin
            act_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= 2'd0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         for (int d = 0; d <= QB; d++) begin
            dv_ff[d] <= 1'b0;
         end
         act_ff <= 1'b0;
         row_ff <= 2'd0;
      end else begin
         gap_ff   <= gap_in;
         v1_ff    <= accept;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         v6_ff    <= v5_ff;
         v7_ff    <= v6_ff;
         v8_ff    <= v7_ff;
         dv_ff[0] <= v8_ff;
         for (int d = 0; d < QB; d++) begin
            dv_ff[d+1] <= dv_ff[d];
         end
         act_ff <= act_in;
         row_ff <= row_in;
      end
   end

   assign rsp_valid = act_ff;
   always_comb begin
      rsp_data.row_index  = row_ff;
      rsp_data.entry0     = ent_ff[PAIR_OF[row_ff][0]];
      rsp_data.entry1     = ent_ff[PAIR_OF[row_ff][1]];
      rsp_data.entry2     = ent_ff[PAIR_OF[row_ff][2]];
      rsp_data.entry3     = ent_ff[PAIR_OF[row_ff][3]];
      rsp_data.last_row   = (row_ff == 2'd3);
      rsp_data.degenerate = odg_ff;
   end

   `TES_ASSERT_NEXT(a_accept_spacing, clock, reset, accept, busy, "transfer not followed by busy")
   `TES_ASSERT_NEXT(a_rows_run, clock, reset, act_ff && row_ff != 2'd3, act_ff, "row burst broken")
   `TES_ASSERT_IMPL(a_no_overrun, clock, reset, dv_ff[QB], !act_ff || row_ff == 2'd3, "element overruns rows")
   `TES_ASSERT_IMPL(a_degen_zero, clock, reset, rsp_valid && rsp_data.degenerate, rsp_data.entry0 == '0 && rsp_data.entry3 == '0, "degenerate entry nonzero")
endmodule
